### design/css_split_pkg.sv
// ----------------------------------------------------------------------------
// css_split_pkg
// Shared word types, character codes, role codes and bracket helpers.
// ----------------------------------------------------------------------------
package css_split_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_req;
    } t_in_word;

    typedef struct packed {
        logic [7:0] text_byte;
        logic [2:0] role;
        logic       declaration_valid;
    } t_out_word;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result roles
    localparam logic [2:0] ROLE_NAME  = 3'd0;
    localparam logic [2:0] ROLE_COLON = 3'd1;
    localparam logic [2:0] ROLE_VALUE = 3'd2;
    localparam logic [2:0] ROLE_SEMI  = 3'd3;
    localparam logic [2:0] ROLE_END   = 3'd4;

    // quote state
    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    // bracket codes
    localparam logic [1:0] BR_NONE  = 2'd0;
    localparam logic [1:0] BR_PAREN = 2'd1;
    localparam logic [1:0] BR_SQUARE = 2'd2;
    localparam logic [1:0] BR_CURLY = 2'd3;

    // characters
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    // stack control from parser, status back from stack
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [1:0] code;
    } t_stk_cmd;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] top;
    } t_stk_stat;

    function automatic logic [1:0] opener_code(input logic [7:0] c);
        logic [1:0] code;
        case (c)
            CH_LPAREN: code = BR_PAREN;
            CH_LSQ:    code = BR_SQUARE;
            CH_LCURLY: code = BR_CURLY;
            default:   code = BR_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] closer_code(input logic [7:0] c);
        logic [1:0] code;
        case (c)
            CH_RPAREN: code = BR_PAREN;
            CH_RSQ:    code = BR_SQUARE;
            CH_RCURLY: code = BR_CURLY;
            default:   code = BR_NONE;
        endcase
        return code;
    endfunction

endpackage

### design/css_declaration_splitter_top.sv
// ----------------------------------------------------------------------------
// css_declaration_splitter_top
// Splits style attribute text into declarations, one byte word per cycle while o_in_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one text byte
//   per word (op = byte) and finally one end-of-text word (op = end).
//   Output channel (o_out_valid / i_out_stall / o_out_word) returns exactly
//   one result word per input word, in order: the echoed byte, its role
//   (name, split colon, value, semicolon boundary, end) and, on boundary
//   and end roles, whether the closed declaration is kept.
// Timing:
//   Each accepted word is registered in the result register or skid slot.
//   Throughput is one word per cycle while o_in_stall is low; all flag and
//   stack-top updates finish in the accept cycle. The bracket stack is a
//   chain of STACK_DEPTH cells that shift together on push and pop, so the
//   top is always cell 0 and no memory port limits the rate.
// Reset / stall:
//   Synchronous active-low reset clears all parser flags, the stack depth
//   and both output slots; cell contents stay undefined until pushed.
//   The output has a result register plus one skid slot: the block keeps
//   accepting while a result waits, and raises o_in_stall (a registered
//   signal) only once the skid slot is full. An end word returns the
//   parser to its reset state.
// ----------------------------------------------------------------------------
module css_declaration_splitter_top #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  css_split_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output css_split_pkg::t_out_word o_out_word
);

    // parser state
    logic       r_in_comment,     n_in_comment;
    logic       r_star_pending,   n_star_pending;
    logic       r_slash_pending,  n_slash_pending;
    logic       r_escape_pending, n_escape_pending;
    logic [1:0] r_quote_kind,     n_quote_kind;
    logic       r_colon_seen,     n_colon_seen;

    // output register and skid slot
    logic                     r_out_valid;
    css_split_pkg::t_out_word r_out_word;
    logic                     r_skid_valid;
    css_split_pkg::t_out_word r_skid_word;

    css_split_pkg::t_out_word  w_res;
    css_split_pkg::t_stk_cmd   w_cmd;
    css_split_pkg::t_stk_stat  w_stat;

    logic       w_in_fire;
    logic       w_out_fire;
    logic [7:0] w_c;
    logic [1:0] w_open;
    logic [1:0] w_close;

    assign o_in_stall = r_skid_valid;
    assign w_in_fire  = i_in_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && !i_out_stall;

    assign w_c     = i_in_word.byte_req;
    assign w_open  = css_split_pkg::opener_code(w_c);
    assign w_close = css_split_pkg::closer_code(w_c);

    // ---- per-word parse, priority follows the tokenizer rules ----
    always_comb begin
        n_in_comment     = r_in_comment;
        n_star_pending   = r_star_pending;
        n_slash_pending  = r_slash_pending;
        n_escape_pending = r_escape_pending;
        n_quote_kind     = r_quote_kind;
        n_colon_seen     = r_colon_seen;
        w_cmd            = '0;
        w_cmd.code       = w_open;
        w_res.text_byte  = w_c;
        w_res.role       = r_colon_seen ? css_split_pkg::ROLE_VALUE
                                        : css_split_pkg::ROLE_NAME;
        w_res.declaration_valid = 1'b0;

        if (i_in_word.op == css_split_pkg::OP_END) begin
            w_res.text_byte = '0;
            w_res.role      = css_split_pkg::ROLE_END;
            w_res.declaration_valid = !r_in_comment && !r_escape_pending &&
                (r_quote_kind == css_split_pkg::QUOTE_NONE) && r_colon_seen;
            n_in_comment     = 1'b0;
            n_star_pending   = 1'b0;
            n_slash_pending  = 1'b0;
            n_escape_pending = 1'b0;
            n_quote_kind     = css_split_pkg::QUOTE_NONE;
            n_colon_seen     = 1'b0;
            w_cmd.clear      = 1'b1;
        end else begin
            n_slash_pending = 1'b0;
            if (r_in_comment) begin
                if (r_star_pending && w_c == css_split_pkg::CH_SLASH) begin
                    n_in_comment   = 1'b0;
                    n_star_pending = 1'b0;
                end else begin
                    n_star_pending = (w_c == css_split_pkg::CH_STAR);
                end
            end else if (r_escape_pending) begin
                n_escape_pending = 1'b0;
            end else if (w_c == css_split_pkg::CH_BSLASH) begin
                n_escape_pending = 1'b1;
            end else if (r_quote_kind != css_split_pkg::QUOTE_NONE) begin
                if ((r_quote_kind == css_split_pkg::QUOTE_DOUBLE &&
                     w_c == css_split_pkg::CH_DQUOTE) ||
                    (r_quote_kind == css_split_pkg::QUOTE_SINGLE &&
                     w_c == css_split_pkg::CH_SQUOTE)) begin
                    n_quote_kind = css_split_pkg::QUOTE_NONE;
                end
            end else if (r_slash_pending && w_c == css_split_pkg::CH_STAR) begin
                // the opening star never closes the comment
                n_in_comment   = 1'b1;
                n_star_pending = 1'b0;
            end else if (w_c == css_split_pkg::CH_DQUOTE) begin
                n_quote_kind = css_split_pkg::QUOTE_DOUBLE;
            end else if (w_c == css_split_pkg::CH_SQUOTE) begin
                n_quote_kind = css_split_pkg::QUOTE_SINGLE;
            end else if (w_open != css_split_pkg::BR_NONE) begin
                // opener beyond the stack limit is dropped
                w_cmd.push = !w_stat.full;
            end else if (w_close != css_split_pkg::BR_NONE) begin
                // unmatched closers leave the stack alone
                w_cmd.pop = !w_stat.empty && (w_stat.top == w_close);
            end else if (w_stat.empty && w_c == css_split_pkg::CH_COLON &&
                         !r_colon_seen) begin
                n_colon_seen = 1'b1;
                w_res.role   = css_split_pkg::ROLE_COLON;
            end else if (w_stat.empty && w_c == css_split_pkg::CH_SEMI) begin
                w_res.role              = css_split_pkg::ROLE_SEMI;
                w_res.declaration_valid = r_colon_seen;
                n_colon_seen            = 1'b0;
            end else if (w_c == css_split_pkg::CH_SLASH) begin
                n_slash_pending = 1'b1;
            end
        end

        if (!w_in_fire) begin
            w_cmd.push  = 1'b0;
            w_cmd.pop   = 1'b0;
            w_cmd.clear = 1'b0;
        end
    end

    css_split_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment     <= 1'b0;
            r_star_pending   <= 1'b0;
            r_slash_pending  <= 1'b0;
            r_escape_pending <= 1'b0;
            r_quote_kind     <= css_split_pkg::QUOTE_NONE;
            r_colon_seen     <= 1'b0;
        end else if (w_in_fire) begin
            r_in_comment     <= n_in_comment;
            r_star_pending   <= n_star_pending;
            r_slash_pending  <= n_slash_pending;
            r_escape_pending <= n_escape_pending;
            r_quote_kind     <= n_quote_kind;
            r_colon_seen     <= n_colon_seen;
        end
    end

    // ---- result register with skid slot ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (w_in_fire) begin
                r_out_word <= w_res;
            end
        end else if (w_in_fire) begin
            r_skid_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---- assertions ----
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a word while output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("word accepted under output stall was not parked");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in_word.op == css_split_pkg::OP_END) |=>
        (!r_colon_seen && w_stat.empty &&
         r_quote_kind == css_split_pkg::QUOTE_NONE && !r_in_comment))
        else $error("parser state not cleared after end word");

    a_comment_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_comment |-> (!r_escape_pending && !r_slash_pending &&
                          r_quote_kind == css_split_pkg::QUOTE_NONE))
        else $error("comment overlaps quote, escape or pending slash");

endmodule

### design/css_split_cell.sv
// ----------------------------------------------------------------------------
// css_split_cell
// One bracket stack slot; shifts down on push, up on pop.
// ----------------------------------------------------------------------------
module css_split_cell (
    input  logic       i_clk,
    input  logic       i_push,
    input  logic       i_pop,
    input  logic [1:0] i_from_up,
    input  logic [1:0] i_from_down,
    output logic [1:0] o_code
);

    logic [1:0] r_code;
    logic [1:0] n_code;

    always_comb begin
        n_code = r_code;
        if (i_push) begin
            n_code = i_from_up;
        end else if (i_pop) begin
            n_code = i_from_down;
        end
    end

    // payload only, contents are don't-care until pushed
    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

### design/css_split_stack.sv
// ----------------------------------------------------------------------------
// css_split_stack
// Bracket stack as a chain of shifting cells plus a depth counter.
// ----------------------------------------------------------------------------
module css_split_stack #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  css_split_pkg::t_stk_cmd  i_cmd,
    output css_split_pkg::t_stk_stat o_stat
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;

    // chain[0] feeds the top cell, chain[i+1] is cell i, last entry fills the bottom
    logic [1:0] w_chain [STACK_DEPTH+2];

    assign w_chain[0]             = i_cmd.code;
    assign w_chain[STACK_DEPTH+1] = css_split_pkg::BR_NONE;

    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        css_split_cell u_cell (
            .i_clk       (i_clk),
            .i_push      (i_cmd.push),
            .i_pop       (i_cmd.pop),
            .i_from_up   (w_chain[gi]),
            .i_from_down (w_chain[gi+2]),
            .o_code      (w_chain[gi+1])
        );
    end

    always_comb begin
        n_depth = r_depth;
        if (i_cmd.clear) begin
            n_depth = '0;
        end else if (i_cmd.push) begin
            n_depth = r_depth + DW'(1);
        end else if (i_cmd.pop) begin
            n_depth = r_depth - DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    assign o_stat.empty = (r_depth == '0);
    assign o_stat.full  = (r_depth == DW'(STACK_DEPTH));
    assign o_stat.top   = w_chain[1];

endmodule

### bench/css_declaration_splitter_checker.sv
// ----------------------------------------------------------------------------
// css_declaration_splitter_checker
// Watches both channels of the declaration splitter, predicts one result
// word per accepted input word and compares the results in order.
// ----------------------------------------------------------------------------
module css_declaration_splitter_checker #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  css_split_pkg::t_in_word  i_in_word,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  css_split_pkg::t_out_word i_out_word,
    output int                       o_fail_count,
    output int                       o_pending
);

    // parser copy
    logic       cmt_open;
    logic       star_seen;
    logic       slash_seen;
    logic       esc_open;
    logic       colon_seen;
    logic [1:0] quote_state;
    int         nest_depth;
    logic [1:0] bracket_codes [STACK_DEPTH];

    css_split_pkg::t_out_word split_results_q[$];
    int                       fail_count = 0;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic void clear_parser();
        cmt_open    = 1'b0;
        star_seen   = 1'b0;
        slash_seen  = 1'b0;
        esc_open    = 1'b0;
        colon_seen  = 1'b0;
        quote_state = css_split_pkg::QUOTE_NONE;
        nest_depth  = 0;
    endfunction

    // one input word -> one result word, advancing the parser copy
    function automatic css_split_pkg::t_out_word split_word(
        input css_split_pkg::t_in_word w
    );
        css_split_pkg::t_out_word r;
        logic                     prev_slash;
        logic [7:0]               c;
        logic [1:0]               oc;
        logic [1:0]               cc;
        c = w.byte_req;
        r.text_byte = c;
        r.role = colon_seen ? css_split_pkg::ROLE_VALUE : css_split_pkg::ROLE_NAME;
        r.declaration_valid = 1'b0;
        if (w.op == css_split_pkg::OP_END) begin
            r.text_byte = 8'h00;
            r.role = css_split_pkg::ROLE_END;
            r.declaration_valid = !cmt_open && !esc_open &&
                                  quote_state == css_split_pkg::QUOTE_NONE &&
                                  colon_seen;
            clear_parser();
            return r;
        end
        oc = css_split_pkg::BR_NONE;
        cc = css_split_pkg::BR_NONE;
        case (c)
            css_split_pkg::CH_LPAREN: oc = css_split_pkg::BR_PAREN;
            css_split_pkg::CH_LSQ:    oc = css_split_pkg::BR_SQUARE;
            css_split_pkg::CH_LCURLY: oc = css_split_pkg::BR_CURLY;
            css_split_pkg::CH_RPAREN: cc = css_split_pkg::BR_PAREN;
            css_split_pkg::CH_RSQ:    cc = css_split_pkg::BR_SQUARE;
            css_split_pkg::CH_RCURLY: cc = css_split_pkg::BR_CURLY;
            default: ;
        endcase
        prev_slash = slash_seen;
        slash_seen = 1'b0;
        if (cmt_open) begin
            if (star_seen && c == css_split_pkg::CH_SLASH) begin
                cmt_open  = 1'b0;
                star_seen = 1'b0;
            end else begin
                star_seen = (c == css_split_pkg::CH_STAR);
            end
        end else if (esc_open) begin
            esc_open = 1'b0;
        end else if (c == css_split_pkg::CH_BSLASH) begin
            esc_open = 1'b1;
        end else if (quote_state != css_split_pkg::QUOTE_NONE) begin
            if ((quote_state == css_split_pkg::QUOTE_DOUBLE &&
                 c == css_split_pkg::CH_DQUOTE) ||
                (quote_state == css_split_pkg::QUOTE_SINGLE &&
                 c == css_split_pkg::CH_SQUOTE)) begin
                quote_state = css_split_pkg::QUOTE_NONE;
            end
        end else if (prev_slash && c == css_split_pkg::CH_STAR) begin
            cmt_open  = 1'b1;
            star_seen = 1'b0;
        end else if (c == css_split_pkg::CH_DQUOTE) begin
            quote_state = css_split_pkg::QUOTE_DOUBLE;
        end else if (c == css_split_pkg::CH_SQUOTE) begin
            quote_state = css_split_pkg::QUOTE_SINGLE;
        end else if (oc != css_split_pkg::BR_NONE) begin
            if (nest_depth < STACK_DEPTH) begin
                bracket_codes[nest_depth] = oc;
                nest_depth++;
            end
        end else if (cc != css_split_pkg::BR_NONE) begin
            if (nest_depth > 0 && bracket_codes[nest_depth-1] == cc) begin
                nest_depth--;
            end
        end else if (nest_depth == 0 && c == css_split_pkg::CH_COLON && !colon_seen) begin
            colon_seen = 1'b1;
            r.role = css_split_pkg::ROLE_COLON;
        end else if (nest_depth == 0 && c == css_split_pkg::CH_SEMI) begin
            r.role = css_split_pkg::ROLE_SEMI;
            r.declaration_valid = colon_seen;
            colon_seen = 1'b0;
        end else if (c == css_split_pkg::CH_SLASH) begin
            slash_seen = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        css_split_pkg::t_out_word want;
        if (!i_rst_n) begin
            clear_parser();
            split_results_q.delete();
        end else begin
            // result side first: a word accepted now cannot answer this edge
            if (i_out_valid && !i_out_stall) begin
                if (split_results_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected word: byte %02h role %0d valid %0b",
                                 i_out_word.text_byte, i_out_word.role,
                                 i_out_word.declaration_valid);
                    end
                    fail_count++;
                end else begin
                    want = split_results_q.pop_front();
                    if (i_out_word.text_byte !== want.text_byte ||
                        i_out_word.role !== want.role ||
                        i_out_word.declaration_valid !== want.declaration_valid) begin
                        if (fail_count < 10) begin
                            $display({"mismatch: want byte %02h role %0d valid %0b,",
                                      " got byte %02h role %0d valid %0b"},
                                     want.text_byte, want.role, want.declaration_valid,
                                     i_out_word.text_byte, i_out_word.role,
                                     i_out_word.declaration_valid);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                split_results_q.push_back(split_word(i_in_word));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= split_results_q.size();
    end

endmodule

### bench/css_declaration_splitter_top_tb.sv
// ----------------------------------------------------------------------------
// css_declaration_splitter_top_tb
// Drives style attribute text into the declaration splitter: a short
// directed string of corner cases, then random attributes (mostly well
// formed, some broken, some raw noise, a few deep bracket nests). Both
// channels idle at random; the checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module css_declaration_splitter_top_tb;

    localparam int STACK_DEPTH = 128;
    localparam int N_WORDS     = 1200;     // stimulus stops past this count
    localparam int CYCLE_LIMIT = 400000;   // ~10x the slowest legal run
    localparam int LONG_HOLD   = 300;      // receiver hold-off, in cycles

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    css_split_pkg::t_in_word  in_word   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    css_split_pkg::t_out_word out_word;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        words_sent  = 0;

    // idle-free stretches on each side, flipped now and then
    bit        tx_burst     = 1'b0;
    bit        rx_burst     = 1'b0;
    // set by the sender, cleared by the receiver once the hold-off is done
    bit        hold_request = 1'b0;

    // attribute text waiting to go out, one byte word each
    logic [7:0] text_q[$];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    css_declaration_splitter_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    css_declaration_splitter_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("css_declaration_splitter_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Text helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] letter();
        logic [7:0] r;
        r = 8'($urandom_range(0, 25));
        return 8'h61 + r;
    endfunction

    function automatic logic [7:0] any_byte();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // k: 0 paren, 1 square, 2 curly
    function automatic logic [7:0] bracket_char(input int k, input bit closing);
        case (k)
            0:       return closing ? css_split_pkg::CH_RPAREN : css_split_pkg::CH_LPAREN;
            1:       return closing ? css_split_pkg::CH_RSQ : css_split_pkg::CH_LSQ;
            default: return closing ? css_split_pkg::CH_RCURLY : css_split_pkg::CH_LCURLY;
        endcase
    endfunction

    // filler for quotes, comments and brackets: colons and semicolons
    // there must stay plain bytes
    function automatic logic [7:0] filler();
        case ($urandom_range(0, 7))
            0:       return css_split_pkg::CH_COLON;
            1:       return css_split_pkg::CH_SEMI;
            2:       return 8'h20;
            3:       return 8'h2C;
            default: return letter();
        endcase
    endfunction

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Channel driving
    // ------------------------------------------------------------------
    // valid is lowered only when a gap follows, so a back-to-back word
    // never sees valid dropped and raised in one step
    task automatic send_word(input logic op, input logic [7:0] b);
        int                      gap;
        css_split_pkg::t_in_word w;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 49) == 0) begin
            tx_burst = !tx_burst;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.op = op;
        w.byte_req = b;
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic flush_text();
        while (text_q.size() > 0) begin
            send_word(css_split_pkg::OP_BYTE, text_q.pop_front());
        end
    endtask

    // sender goes quiet until every result word is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // ------------------------------------------------------------------
    // Attribute generators
    // ------------------------------------------------------------------
    task automatic add_piece();
        int         n;
        int         i;
        int         k;
        logic [7:0] q;
        logic [7:0] shut[$];
        case ($urandom_range(0, 9))
            0, 1: begin
                repeat ($urandom_range(1, 4)) text_q.push_back(letter());
            end
            2: text_q.push_back(8'h20);
            3: begin
                // quoted string, escapes inside it too
                q = $urandom_range(0, 1) ? css_split_pkg::CH_DQUOTE
                                         : css_split_pkg::CH_SQUOTE;
                text_q.push_back(q);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        text_q.push_back(css_split_pkg::CH_BSLASH);
                        text_q.push_back(any_byte());
                    end else if ($urandom_range(0, 5) == 0) begin
                        text_q.push_back(q == css_split_pkg::CH_DQUOTE
                                         ? css_split_pkg::CH_SQUOTE
                                         : css_split_pkg::CH_DQUOTE);
                    end else begin
                        text_q.push_back(filler());
                    end
                end
                text_q.push_back(q);
            end
            4: begin
                // comment with stray stars inside
                text_q.push_back(css_split_pkg::CH_SLASH);
                text_q.push_back(css_split_pkg::CH_STAR);
                repeat ($urandom_range(0, 5)) begin
                    text_q.push_back($urandom_range(0, 3) == 0 ? css_split_pkg::CH_STAR
                                                               : filler());
                end
                text_q.push_back(css_split_pkg::CH_STAR);
                text_q.push_back(css_split_pkg::CH_SLASH);
            end
            5: begin
                text_q.push_back(css_split_pkg::CH_BSLASH);
                text_q.push_back(any_byte());
            end
            6: begin
                // balanced bracket nest, up to three deep
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    k = $urandom_range(0, 2);
                    text_q.push_back(bracket_char(k, 1'b0));
                    shut.push_front(bracket_char(k, 1'b1));
                    text_q.push_back(filler());
                end
                while (shut.size() > 0) begin
                    text_q.push_back(filler());
                    text_q.push_back(shut.pop_front());
                end
            end
            7: text_q.push_back(css_split_pkg::CH_COLON);
            8: begin
                // slash not opening a comment
                text_q.push_back(css_split_pkg::CH_SLASH);
                text_q.push_back(letter());
            end
            default: text_q.push_back(any_byte());
        endcase
    endtask

    task automatic add_declaration();
        repeat ($urandom_range(1, 5)) begin
            text_q.push_back($urandom_range(0, 6) == 0 ? 8'h2D : letter());
        end
        if ($urandom_range(0, 7) == 0) begin
            add_piece();
        end
        if ($urandom_range(0, 9) != 0) begin
            text_q.push_back(css_split_pkg::CH_COLON);
        end
        repeat ($urandom_range(1, 5)) add_piece();
    endtask

    task automatic send_attribute();
        int n;
        int i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            add_declaration();
            if (i < n - 1 || $urandom_range(0, 1) == 1) begin
                text_q.push_back(css_split_pkg::CH_SEMI);
            end
        end
        flush_text();
        send_word(css_split_pkg::OP_END, any_byte());
    endtask

    // well-formed start, then something that leaves the text open or odd
    task automatic send_broken();
        add_declaration();
        case ($urandom_range(0, 5))
            0: add_text("\"ab");
            1: add_text("'cd");
            2: add_text("/*e*");
            3: add_text("x\\");
            4: add_text(")]};y");
            default: add_text("(;:");
        endcase
        flush_text();
        send_word(css_split_pkg::OP_END, any_byte());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 20)) text_q.push_back(any_byte());
        flush_text();
        send_word(css_split_pkg::OP_END, any_byte());
    endtask

    // openers past the stack depth are dropped by the block
    task automatic send_deep_nest(input int levels);
        int         i;
        int         k;
        logic [7:0] shut[$];
        add_text("z:");
        for (i = 0; i < levels; i++) begin
            k = $urandom_range(0, 2);
            text_q.push_back(bracket_char(k, 1'b0));
            shut.push_front(bracket_char(k, 1'b1));
        end
        text_q.push_back(css_split_pkg::CH_SEMI);
        while (shut.size() > 0) text_q.push_back(shut.pop_front());
        text_q.push_back(css_split_pkg::CH_SEMI);
        flush_text();
        send_word(css_split_pkg::OP_END, 8'h00);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per word, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int hold;
        forever begin
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            hold = rx_burst ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 49) == 0) begin
                rx_burst = !rx_burst;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender and verdict
    // ------------------------------------------------------------------
    initial begin
        int  pick;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: null byte in the name, unmatched closer at depth zero,
        // slash-star-slash (the opening star cannot close), semicolon with
        // no colon, split colon then a later colon, semicolon inside a
        // bracket, mismatched closer, escaped quote inside a quote, 0xFF,
        // kept semicolon, end after a boundary, end inside an escape.
        text_q.push_back(8'h00);
        add_text(")/*/*/;a::(;])\"\\\"\"");
        text_q.push_back(8'hFF);
        text_q.push_back(css_split_pkg::CH_SEMI);
        flush_text();
        send_word(css_split_pkg::OP_END, 8'hFF);
        add_text(":\\");
        flush_text();
        send_word(css_split_pkg::OP_END, 8'h00);
        drain();

        // stack overflow case up front
        send_deep_nest(STACK_DEPTH + 2);

        while (words_sent < N_WORDS) begin
            if (!hold_done && words_sent >= 400) begin
                // receiver freezes while words keep coming: the block fills
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && words_sent >= 800) begin
                drain();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_attribute();
            end else if (pick < 87) begin
                send_broken();
            end else if (pick < 99) begin
                send_noise();
            end else begin
                send_deep_nest($urandom_range(20, STACK_DEPTH + 6));
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("css_declaration_splitter_top test passed");
        end else begin
            $display("css_declaration_splitter_top test failed");
        end
        $finish;
    end

endmodule
